[design/tmcw_pkg.sv]
// tmcw_pkg: types and constants shared by the text-mode console writer,
// its port checker and its testbench. No dependencies.
`default_nettype none

package tmcw_pkg;

  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int CELL_W  = 16;
  localparam int ATTR_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h07;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

[design/text_mode_console_writer_unit.sv]
// Text-mode console writer: screen memory, cursor and command sequencer.
// Depends on tmcw_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_ready  | cmd, char_code, cell_index
//  out     | output    | out_valid / out_ready| cursor_position, cell_data
//  cfg     | input     | cfg_valid / cfg_ready| color_attribute (always ready)
//
// put, the unused command and an out-of-range read go from acceptance to ST_RESULT, an
// in-range read through ST_READ first; ST_RESULT loads the result once the output register
// is free, and the next item is taken the cycle after. a scroll walks the whole screen
// through the single memory port pair and a clear fills it, each ending in ST_RESULT.
// after reset the screen is blanked one cell a cycle with in_ready low; cfg writes are
// taken throughout. a stalled result holds in the output register while the next item
// is already accepted.
`default_nettype none

module text_mode_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [tmcw_pkg::CMD_W-1:0]   cmd,
  input  wire  [tmcw_pkg::CHAR_W-1:0]  char_code,
  input  wire  [tmcw_pkg::INDEX_W-1:0] cell_index,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [tmcw_pkg::INDEX_W-1:0] cursor_position,
  output logic [tmcw_pkg::CELL_W-1:0]  cell_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [tmcw_pkg::ATTR_W-1:0]  color_attribute
);
  import tmcw_pkg::*;

  localparam int CELLS     = ROWS * COLUMNS;
  localparam int COPY_CNT  = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLUMNS);

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(COPY_CNT);
  localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

  // screen memory, one write and one registered read per cycle
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata;
  logic [ADDR_W-1:0] rd_addr;

  state_t            state, state_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ADDR_W-1:0] row_base, row_base_next;
  logic [ATTR_W-1:0] attribute;

  // queued cell write, registered from the decision and performed in the following cycle
  logic              wr_en, wr_en_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic              wr_copy, wr_copy_next;
  logic [CELL_W-1:0] wr_val, wr_val_next;

  logic [CELL_W-1:0] res_data, res_data_next;
  logic              load_out;

  logic [ADDR_W-1:0] lin;
  logic [CELL_W-1:0] blank;
  logic              accept;

  assign lin       = row_base + ADDR_W'(col);
  assign blank     = {attribute, CHAR_SPACE};
  assign in_ready  = (state == ST_IDLE) && !wr_en;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_copy ? rdata : wr_val;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      ptr       <= '0;
      row       <= '0;
      col       <= '0;
      row_base  <= '0;
      wr_en     <= 1'b0;
      attribute <= RESET_ATTR;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      row      <= row_next;
      col      <= col_next;
      row_base <= row_base_next;
      wr_en    <= wr_en_next;
      if (cfg_valid && cfg_ready) begin
        attribute <= color_attribute;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr  <= wr_addr_next;
    wr_copy  <= wr_copy_next;
    wr_val   <= wr_val_next;
    res_data <= res_data_next;
    if (load_out) begin
      cursor_position <= INDEX_W'(lin);
      cell_data       <= res_data;
    end
  end

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    row_next      = row;
    col_next      = col;
    row_base_next = row_base;
    wr_en_next    = 1'b0;
    wr_addr_next  = wr_addr;
    wr_copy_next  = 1'b0;
    wr_val_next   = wr_val;
    res_data_next = res_data;
    rd_addr       = '0;
    load_out      = 1'b0;

    case (state)
      ST_INIT: begin
        wr_en_next   = 1'b1;
        wr_addr_next = ptr;
        wr_val_next  = {RESET_ATTR, CHAR_SPACE};
        if (ptr == LAST_CELL) begin
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          res_data_next = '0;
          state_next    = ST_RESULT;
          case (cmd_t'(cmd))
            CMD_PUT: begin
              if (char_code == CHAR_NEWLINE) begin
                col_next = '0;
                if (row == LAST_ROW) begin
                  row_base_next = LAST_BASE;
                  ptr_next      = '0;
                  state_next    = ST_SCROLL;
                end else begin
                  row_next      = row + 1'b1;
                  row_base_next = row_base + COL_STEP;
                end
              end else if (char_code == CHAR_BACKSPACE) begin
                if (col != '0) begin
                  col_next     = col - 1'b1;
                  wr_en_next   = 1'b1;
                  wr_addr_next = lin - 1'b1;
                  wr_val_next  = blank;
                end
              end else begin
                wr_en_next   = 1'b1;
                wr_addr_next = lin;
                wr_val_next  = {attribute, char_code};
                if (col == LAST_COL) begin
                  // end of row wraps like a newline
                  col_next = '0;
                  if (row == LAST_ROW) begin
                    row_base_next = LAST_BASE;
                    ptr_next      = '0;
                    state_next    = ST_SCROLL;
                  end else begin
                    row_next      = row + 1'b1;
                    row_base_next = row_base + COL_STEP;
                  end
                end else begin
                  col_next = col + 1'b1;
                end
              end
            end
            CMD_CLEAR: begin
              row_next      = '0;
              col_next      = '0;
              row_base_next = '0;
              ptr_next      = '0;
              state_next    = ST_FILL;
            end
            CMD_READ: begin
              if (32'(cell_index) < CELLS) begin
                rd_addr    = ADDR_W'(cell_index);
                state_next = ST_READ;
              end
            end
            default: begin
              state_next = ST_RESULT;
            end
          endcase
        end
      end

      ST_READ: begin
        res_data_next = rdata;
        state_next    = ST_RESULT;
      end

      ST_SCROLL: begin
        // read one row ahead, write the cell back in the next cycle
        wr_en_next   = 1'b1;
        wr_addr_next = ptr;
        wr_val_next  = blank;
        if (32'(ptr) < COPY_CNT) begin
          rd_addr      = ptr + COL_STEP;
          wr_copy_next = 1'b1;
        end
        if (ptr == LAST_CELL) begin
          state_next = ST_RESULT;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      ST_FILL: begin
        wr_en_next   = 1'b1;
        wr_addr_next = ptr;
        wr_val_next  = blank;
        if (ptr == LAST_CELL) begin
          state_next = ST_RESULT;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/tmcw_checker.sv]
// tmcw_checker: port-level checks on the console writer, bound into text_mode_console_writer_unit.
// Depends on tmcw_pkg and text_mode_console_writer_unit.
`default_nettype none

module tmcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [tmcw_pkg::INDEX_W-1:0]  cursor_position,
  input wire [tmcw_pkg::CELL_W-1:0]   cell_data
);
  import tmcw_pkg::*;

  // items accepted but not yet delivered
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'((in_valid && in_ready) ? 1 : 0)
                         - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_position) && $stable(cell_data))
    else $error("stalled result changed");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is at work");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0 && pending != 2'd3)
    else $error("result without an item");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(cursor_position) < ROWS * COLUMNS)
    else $error("cursor off screen");

endmodule

bind text_mode_console_writer_unit tmcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS(ROWS)
) u_tmcw_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .cursor_position(cursor_position),
  .cell_data(cell_data)
);

`default_nettype wire

[verif/text_mode_console_writer_unit_test.sv]
// testbench for text_mode_console_writer_unit: drives put, clear, read and unused-command items
// and attribute writes, with random idling on both channels, and checks every result against a
// screen and cursor tracker; depends on tmcw_pkg and the console writer rtl
module text_mode_console_writer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tmcw_pkg::*;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  // bound for the worst case: 1520 items each scrolling or clearing with both stalls, x4
  localparam int unsigned CYCLE_LIMIT = 12_000_000;

  typedef struct packed {
    logic [INDEX_W-1:0] cursor_position;
    logic [CELL_W-1:0]  cell_data;
  } console_result_t;

  class console_screen_tracker;
    logic [CELL_W-1:0] screen [CELL_COUNT];
    int unsigned       row;
    int unsigned       col;
    logic [ATTR_W-1:0] attr;
    console_result_t   awaited_results [$];
    int unsigned       failures;

    function new();
      row = 0;
      col = 0;
      attr = RESET_ATTR;
      failures = 0;
      foreach (screen[i]) screen[i] = {RESET_ATTR, CHAR_SPACE};
    endfunction

    function logic [INDEX_W-1:0] cursor_now();
      return INDEX_W'(row * COLUMNS + col);
    endfunction

    // column 0 of the next row, scrolling when the last row is left
    function void advance_line();
      int i;
      col = 0;
      row++;
      if (row >= ROWS) begin
        for (i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) screen[i] = {attr, CHAR_SPACE};
        row = ROWS - 1;
      end
    endfunction

    function void apply_item(cmd_t op, logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] idx);
      console_result_t r;
      r.cell_data = '0;
      case (op)
        CMD_PUT: begin
          if (ch == CHAR_NEWLINE) begin
            advance_line();
          end else if (ch == CHAR_BACKSPACE) begin
            // no wrap to the row above
            if (col > 0) begin
              col--;
              screen[row * COLUMNS + col] = {attr, CHAR_SPACE};
            end
          end else begin
            screen[row * COLUMNS + col] = {attr, ch};
            col++;
            if (col >= COLUMNS) advance_line();
          end
        end
        CMD_CLEAR: begin
          foreach (screen[i]) screen[i] = {attr, CHAR_SPACE};
          row = 0;
          col = 0;
        end
        CMD_READ: begin
          if (idx < CELL_COUNT) r.cell_data = screen[idx];
        end
        default: ;
      endcase
      r.cursor_position = cursor_now();
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [INDEX_W-1:0] pos, logic [CELL_W-1:0] data);
      console_result_t want;
      if (awaited_results.size() == 0) begin
        failures++;
        $display("%0t: result with no item waiting, expected none, got cursor %0d cell %h",
                 $time, pos, data);
        return;
      end
      want = awaited_results.pop_front();
      if (pos !== want.cursor_position) begin
        failures++;
        $display("%0t: cursor_position expected %0d got %0d",
                 $time, want.cursor_position, pos);
      end
      if (data !== want.cell_data) begin
        failures++;
        $display("%0t: cell_data expected %h got %h", $time, want.cell_data, data);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  cmd_t               cmd;
  logic [CHAR_W-1:0]  char_code;
  logic [INDEX_W-1:0] cell_index;
  logic               out_valid;
  logic               out_ready;
  logic [INDEX_W-1:0] cursor_position;
  logic [CELL_W-1:0]  cell_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [ATTR_W-1:0]  color_attribute;

  console_screen_tracker tracker = new();
  bit                    send_gaps;
  bit                    take_gaps;
  int unsigned           cycle_count;

  text_mode_console_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .char_code      (char_code),
    .cell_index     (cell_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_position(cursor_position),
    .cell_data      (cell_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .color_attribute(color_attribute)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // valid stays high across back-to-back items; this task lowers it only for a gap
  task automatic send_item(input cmd_t op, input logic [CHAR_W-1:0] ch,
                           input logic [INDEX_W-1:0] idx);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    cmd        <= op;
    char_code  <= ch;
    cell_index <= idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.apply_item(op, ch, idx);
  endtask

  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    color_attribute <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.attr = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int unsigned count, input int unsigned nl_pct,
                              input int unsigned clr_pct, input int unsigned rd_pct,
                              input int unsigned bs_pct);
    int unsigned        n;
    int unsigned        r;
    int unsigned        s;
    cmd_t               op;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
    for (n = 0; n < count; n++) begin
      r   = $urandom_range(0, 99);
      ch  = CHAR_W'($urandom_range(0, 255));
      idx = INDEX_W'($urandom_range(0, 2047));
      if (r < clr_pct) begin
        op = CMD_CLEAR;
      end else if (r < clr_pct + rd_pct) begin
        op = CMD_READ;
        s  = $urandom_range(0, 9);
        if (s < 5)
          idx = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
        else if (s < 9)
          // cells just written behind the cursor
          idx = INDEX_W'((tracker.cursor_now() + CELL_COUNT - $urandom_range(1, 3))
                         % CELL_COUNT);
        else
          idx = INDEX_W'($urandom_range(CELL_COUNT, 2047));
      end else if (r < clr_pct + rd_pct + 2) begin
        op = CMD_NONE;
      end else begin
        op = CMD_PUT;
        s  = $urandom_range(0, 99);
        if (s < nl_pct) ch = CHAR_NEWLINE;
        else if (s < nl_pct + bs_pct) ch = CHAR_BACKSPACE;
      end
      send_item(op, ch, idx);
    end
  endtask

  // result side: random stall before each result, ready held until it is taken
  initial begin
    int unsigned stall;
    wait (rst === 1'b0);
    forever begin
      stall = take_gaps ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_result(cursor_position, cell_data);
    end
  end

  initial begin
    int unsigned       p;
    logic [ATTR_W-1:0] value;
    cycle_count     = 0;
    rst             = 1'b1;
    in_valid        = 1'b0;
    cmd             = CMD_PUT;
    char_code       = '0;
    cell_index      = '0;
    out_ready       = 1'b0;
    cfg_valid       = 1'b0;
    color_attribute = '0;
    send_gaps       = 1'b1;
    take_gaps       = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset screen, range edges, unused command, control bytes at the screen corner
    send_item(CMD_READ, 8'h00, 11'd0);
    send_item(CMD_READ, 8'hFF, 11'd1999);
    send_item(CMD_READ, 8'h00, 11'd2000);
    send_item(CMD_READ, 8'h00, 11'h7FF);
    send_item(CMD_NONE, 8'hFF, 11'h7FF);
    send_item(CMD_PUT, CHAR_BACKSPACE, 11'd0);
    send_item(CMD_PUT, 8'h00, 11'h7FF);
    send_item(CMD_PUT, 8'hFF, 11'd0);
    send_item(CMD_PUT, 8'h41, 11'd0);
    send_item(CMD_PUT, CHAR_BACKSPACE, 11'd0);
    send_item(CMD_READ, 8'h00, 11'd1);
    send_item(CMD_READ, 8'h00, 11'd2);
    send_item(CMD_PUT, CHAR_NEWLINE, 11'd0);
    send_item(CMD_PUT, CHAR_BACKSPACE, 11'd0);
    send_item(CMD_PUT, 8'h7E, 11'd0);
    send_item(CMD_READ, 8'h00, 11'd80);
    send_item(CMD_READ, 8'h00, 11'd0);
    send_item(CMD_CLEAR, 8'hFF, 11'h7FF);
    send_item(CMD_READ, 8'h00, 11'd80);
    send_item(CMD_PUT, CHAR_SPACE, 11'd0);
    drain_results();

    for (p = 0; p < 6; p++) begin
      if (p == 0) value = 8'hFF;
      else if (p == 1) value = 8'h00;
      else value = ATTR_W'($urandom_range(0, 255));
      write_attribute(value);
      send_gaps = (p != 2);
      take_gaps = (p != 2 && p != 4);
      case (p)
        0: random_items(250, 10, 1, 20, 5);
        1: random_items(250, 1, 0, 10, 3);   // long lines, wraps at the row end
        2: random_items(250, 25, 2, 25, 10); // frequent scrolling
        3: random_items(250, 8, 1, 25, 30);
        4: random_items(250, 10, 1, 50, 5);
        default: random_items(250, 12, 1, 20, 8);
      endcase
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (tracker.awaited_results.size() != 0) begin
      tracker.failures++;
      $display("%0t: %0d results expected, none arrived", $time,
               tracker.awaited_results.size());
    end
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
